@@ rtl/core/ttg_pkg.sv @@
package ttg_pkg;

    localparam int CLK_HZ_W  = 24;
    localparam int TPM_W     = 16;
    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(CLK_HZ_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK_HZ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS   = 1'b1;

    localparam logic [CLK_HZ_W-1:0] TIMER_CLOCK_HZ_RST = 24'd2000000;
    localparam logic [TPM_W-1:0]    TICKS_PER_MS_RST   = 16'd2000;

    typedef enum logic {
        REQ_TICK = 1'b0,
        REQ_PLAY = 1'b1
    } ttg_req_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DIVIDE = 1'b1
    } ttg_state_t;

    typedef struct packed {
        logic             tick;
        logic             play;
        logic [DUR_W-1:0] dur;
    } ttg_ctl_t;

endpackage

@@ rtl/core/ttg_divider.sv @@
module ttg_divider #(
    parameter int COMPARE_WIDTH = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [ttg_pkg::CLK_HZ_W-1:0]       dividend,
    input  logic [ttg_pkg::FREQ_W-1:0]         freq,
    output logic                               done,
    output logic [COMPARE_WIDTH-1:0]           half_period
);

    localparam int DW = ttg_pkg::CLK_HZ_W;
    localparam int RW = ttg_pkg::FREQ_W + 1;
    localparam logic [ttg_pkg::DIV_CNT_W-1:0] LastStep = ttg_pkg::DIV_CNT_W'(DW);
    localparam logic [31:0] CmpMax = (32'd1 << COMPARE_WIDTH) - 32'd1;

    logic                          busy_reg, busy_next;
    logic [ttg_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]                 dq_reg, dq_next;
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [RW-1:0]                 divisor_reg, divisor_next;
    logic [RW:0]                   trial;
    logic [RW+1:0]                 diff;
    logic [31:0]                   qm1;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial        = {rem_reg, dq_reg[DW-1]};
        diff         = {1'b0, trial} - {2'b00, divisor_reg};
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            dq_next      = dividend;
            rem_next     = '0;
            divisor_next = {freq, 1'b0};
        end else if (busy_reg) begin
            if (cnt_reg == LastStep) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                if (!diff[RW+1]) begin
                    rem_next = diff[RW-1:0];
                    dq_next  = {dq_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = trial[RW-1:0];
                    dq_next  = {dq_reg[DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    // quotient minus one, saturated to the compare range
    always_comb begin
        qm1  = {{(32-DW){1'b0}}, dq_reg} - 32'd1;
        done = busy_reg && (cnt_reg == LastStep);
        if (dq_reg == '0) begin
            half_period = '0;
        end else if (qm1 > CmpMax) begin
            half_period = CmpMax[COMPARE_WIDTH-1:0];
        end else begin
            half_period = qm1[COMPARE_WIDTH-1:0];
        end
    end

endmodule

@@ rtl/core/ttg_tone_core.sv @@
module ttg_tone_core #(
    parameter int COMPARE_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ttg_pkg::ttg_ctl_t               ctl,
    input  logic [ttg_pkg::TPM_W-1:0]       ticks_per_ms,
    input  logic                            hp_load,
    input  logic [COMPARE_WIDTH-1:0]        hp_value,
    output logic                            pin_next,
    output logic                            sounding_next
);

    logic [ttg_pkg::TIME_W-1:0] now_ms_reg, now_ms_next;
    logic [ttg_pkg::TPM_W-1:0]  prescale_reg, prescale_next;
    logic [ttg_pkg::TIME_W-1:0] end_ms_reg, end_ms_next;
    logic [COMPARE_WIDTH-1:0]   half_reg, half_next;
    logic [COMPARE_WIDTH-1:0]   count_reg, count_next;
    logic                       sounding_reg;
    logic                       running_reg, running_next;
    logic                       pin_reg;
    logic [ttg_pkg::TPM_W-1:0]  pre_inc;

    always_comb begin
        pre_inc       = prescale_reg + 1'b1;
        now_ms_next   = now_ms_reg;
        prescale_next = prescale_reg;
        end_ms_next   = end_ms_reg;
        half_next     = hp_load ? hp_value : half_reg;
        count_next    = count_reg;
        sounding_next = sounding_reg;
        running_next  = running_reg;
        pin_next      = pin_reg;
        if (ctl.tick) begin
            if (pre_inc >= ticks_per_ms) begin
                prescale_next = '0;
                now_ms_next   = now_ms_reg + 1'b1;
            end else begin
                prescale_next = pre_inc;
            end
            if (running_reg) begin
                if (count_reg == half_reg) begin
                    count_next = '0;
                    if (sounding_reg) begin
                        if (now_ms_next >= end_ms_reg) begin
                            sounding_next = 1'b0;
                            pin_next      = 1'b0;
                            running_next  = 1'b0;
                        end else begin
                            pin_next = !pin_reg;
                        end
                    end
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end else if (ctl.play) begin
            count_next    = '0;
            end_ms_next   = now_ms_reg + {{(ttg_pkg::TIME_W-ttg_pkg::DUR_W){1'b0}}, ctl.dur};
            sounding_next = 1'b1;
            running_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_ms_reg   <= '0;
            prescale_reg <= '0;
            end_ms_reg   <= '0;
            half_reg     <= '0;
            count_reg    <= '0;
            sounding_reg <= 1'b0;
            running_reg  <= 1'b0;
            pin_reg      <= 1'b0;
        end else begin
            now_ms_reg   <= now_ms_next;
            prescale_reg <= prescale_next;
            end_ms_reg   <= end_ms_next;
            half_reg     <= half_next;
            count_reg    <= count_next;
            sounding_reg <= sounding_next;
            running_reg  <= running_next;
            pin_reg      <= pin_next;
        end
    end

endmodule

@@ rtl/core/timed_tone_generator.sv @@
// Square-wave buzzer driver with a timed tone length. Each input transaction
// is either one prescaled timer tick or a play request carrying a frequency
// and a duration in milliseconds; every transaction returns exactly one
// result transaction with the buzzer level and the tone-active flag after the
// update. Ticks never stall the input, so they can stream back to back as long
// as the result side keeps taking results. A play request with a nonzero
// frequency applies at once (its result is issued right away) but then holds
// s_ready low while a bit-serial restoring divider works out timer_clock_hz /
// (2 * tone_freq), one quotient bit per cycle over the 24-bit dividend, and
// then loads the half-period compare value. A zero frequency is ignored. The
// configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes timer_clock_hz
// (index 0) or ticks_per_ms (index 1) and must only be used while the block
// is idle.
module timed_tone_generator #(
    parameter int COMPARE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [ttg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ttg_pkg::CLK_HZ_W-1:0]      cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [ttg_pkg::FREQ_W-1:0]        s_tone_freq,
    input  logic [ttg_pkg::DUR_W-1:0]         s_duration_ms,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_buzzer_level,
    output logic                              m_tone_active
);

    ttg_pkg::ttg_state_t             state_reg, state_next;
    logic [ttg_pkg::CLK_HZ_W-1:0]    clk_hz_reg;
    logic [ttg_pkg::TPM_W-1:0]       tpm_reg;
    logic                            m_valid_reg, m_valid_next;
    logic                            buzzer_reg, active_reg;
    logic                            accept;
    logic                            div_start, div_done;
    logic [COMPARE_WIDTH-1:0]        div_half;
    ttg_pkg::ttg_ctl_t               ctl;
    logic                            pin_next, sounding_next;

    // Hold off new transactions while dividing or while a result waits.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        div_start  = 1'b0;
        ctl        = '0;
        ctl.dur    = s_duration_ms;
        case (state_reg)
            ttg_pkg::ST_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    if (s_req_type == ttg_pkg::REQ_TICK) begin
                        ctl.tick = 1'b1;
                    end else if (s_tone_freq != '0) begin
                        ctl.play   = 1'b1;
                        div_start  = 1'b1;
                        state_next = ttg_pkg::ST_DIVIDE;
                    end
                end
            end
            ttg_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ttg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttg_pkg::ST_IDLE;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ttg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= ttg_pkg::TIMER_CLOCK_HZ_RST;
            tpm_reg    <= ttg_pkg::TICKS_PER_MS_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == ttg_pkg::CFG_TIMER_CLOCK_HZ) begin
                clk_hz_reg <= cfg_wdata;
            end
            if (cfg_index == ttg_pkg::CFG_TICKS_PER_MS) begin
                tpm_reg <= cfg_wdata[ttg_pkg::TPM_W-1:0];
            end
        end
    end

    ttg_divider #(
        .COMPARE_WIDTH(COMPARE_WIDTH)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .dividend   (clk_hz_reg),
        .freq       (s_tone_freq),
        .done       (div_done),
        .half_period(div_half)
    );

    ttg_tone_core #(
        .COMPARE_WIDTH(COMPARE_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .ticks_per_ms (tpm_reg),
        .hp_load      (div_done),
        .hp_value     (div_half),
        .pin_next     (pin_next),
        .sounding_next(sounding_next)
    );

    // Result register: load on every accepted transaction, drop on take.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (accept) begin
            buzzer_reg <= pin_next;
            active_reg <= sounding_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_buzzer_level = buzzer_reg;
    assign m_tone_active  = active_reg;

endmodule

@@ rtl/core/ttg_checker.sv @@
module ttg_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_req_type,
    input logic [ttg_pkg::FREQ_W-1:0]   s_tone_freq,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_buzzer_level,
    input logic                         m_tone_active
);

    // Every transaction in yields a result on the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transaction");

    // A waiting result is not dropped.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before taken");

    // A silent buzzer is always low.
    a_silent_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tone_active |-> !m_buzzer_level)
        else $error("buzzer high while no tone plays");

    // A real play request starts the tone and stalls input for the division.
    a_play_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type && (s_tone_freq != '0)
        |=> m_valid && m_tone_active && !s_ready)
        else $error("play request did not start tone");

endmodule

bind timed_tone_generator ttg_checker u_ttg_checker (.*);
